// File: rtl/tlb_page_table_translator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the TLB page table translator
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define TLBPT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define TLBPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TLBPT_ASSERT_NOW(label, clk, rst, ante, cons)
`define TLBPT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared constants, types and sequencer states of the TLB page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int TLB_DEPTH   = 16;
  localparam int SLOT_W      = $clog2(TLB_DEPTH);
  localparam int DIV_W       = SLOT_W + 1;
  localparam int CFG_W       = 5;
  localparam int PAGE_W      = 8;
  localparam int OFFSET_W    = 8;
  localparam int ADDR_W      = PAGE_W + OFFSET_W;
  localparam int PAGE_COUNT  = 1 << PAGE_W;
  localparam int FRAME_W     = 8;
  localparam int FRAME_CNT_W = FRAME_W + 1;
  localparam int STEP_W      = $clog2(PAGE_W);
  localparam int CNT_W       = 32;

  localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(TLB_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_LOOKUP,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [PAGE_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } rem_rsp_t;

  typedef struct packed {
    logic               we;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } pt_req_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } pt_rsp_t;

endpackage

// File: rtl/tlbpt_rem_unit.sv
// ----------------------------------------------------------------------------
// tlbpt_rem_unit
// Restoring remainder unit: one compare and subtract per cycle, page bits MSB first.
// ----------------------------------------------------------------------------
module tlbpt_rem_unit (
  input  logic              clk,
  input  logic              rst,
  input  tlbpt_pkg::rem_req_t req,
  output tlbpt_pkg::rem_rsp_t rsp
);

  logic                         busy;
  logic                         done;
  logic [tlbpt_pkg::STEP_W-1:0] step;
  logic [tlbpt_pkg::PAGE_W-1:0] shift;
  logic [tlbpt_pkg::DIV_W-1:0]  divisor;
  logic [tlbpt_pkg::DIV_W-1:0]  rem;
  logic [tlbpt_pkg::DIV_W-1:0]  rem_next;
  logic [tlbpt_pkg::DIV_W-1:0]  trial;

  always_comb begin
    trial    = {rem[tlbpt_pkg::DIV_W-2:0], shift[tlbpt_pkg::PAGE_W-1]};
    rem_next = (trial >= divisor) ? trial - divisor : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == tlbpt_pkg::STEP_W'(tlbpt_pkg::PAGE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shift   <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      shift <= {shift[tlbpt_pkg::PAGE_W-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

// File: rtl/tlbpt_page_table.sv
// ----------------------------------------------------------------------------
// tlbpt_page_table
// Page-to-frame memory with registered read and per-page mapped bits.
// ----------------------------------------------------------------------------
module tlbpt_page_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tlbpt_pkg::PAGE_W-1:0] rd_page,
  input  tlbpt_pkg::pt_req_t           req,
  output tlbpt_pkg::pt_rsp_t           rsp
);

  logic [tlbpt_pkg::FRAME_W-1:0]    mem [tlbpt_pkg::PAGE_COUNT];
  logic [tlbpt_pkg::PAGE_COUNT-1:0] mapped;
  logic [tlbpt_pkg::FRAME_W-1:0]    rd_frame;
  logic                             rd_valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.page] <= req.frame;
    end
    rd_frame <= mem[rd_page];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mapped   <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.we) begin
        mapped[req.page] <= 1'b1;
      end
      rd_valid <= mapped[rd_page];
    end
  end

  assign rsp.frame = rd_frame;
  assign rsp.valid = rd_valid;

endmodule

// File: rtl/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Direct-mapped TLB in front of a 256-entry page table with in-order frame
// allocation on page faults; returns physical address, flags and counts.
//
//   channel  signals                              direction
//   in       in_valid/in_ready, logical_address   request
//   out      out_valid/out_ready, result fields   response
//   cfg      cfg_valid/cfg_ready, tlb_entries     register write
//
// A TLB hit passes from accept through divide and lookup to the result; a miss
// also walks the page table. The slot remainder is bit-serial in the remainder unit.
// The next request is taken the cycle after the result is loaded.
// A held result stalls only the final load; no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "tlb_page_table_translator_macros.svh"

module tlb_page_table_translator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tlbpt_pkg::ADDR_W-1:0]    logical_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tlbpt_pkg::ADDR_W-1:0]    physical_address,
  output logic                            tlb_hit,
  output logic                            fault_flag,
  output logic [tlbpt_pkg::CNT_W-1:0]     translated_count,
  output logic [tlbpt_pkg::CNT_W-1:0]     tlb_hit_count,
  output logic [tlbpt_pkg::CNT_W-1:0]     fault_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlbpt_pkg::CFG_W-1:0]     tlb_entries
);

  tlbpt_pkg::state_t state;
  tlbpt_pkg::state_t state_next;

  tlbpt_pkg::rem_req_t rem_req;
  tlbpt_pkg::rem_rsp_t rem_rsp;
  tlbpt_pkg::pt_req_t  pt_req;
  tlbpt_pkg::pt_rsp_t  pt_rsp;

  logic [tlbpt_pkg::CFG_W-1:0]       entries;
  logic [tlbpt_pkg::DIV_W-1:0]       divisor;
  logic [tlbpt_pkg::PAGE_W-1:0]      page;
  logic [tlbpt_pkg::OFFSET_W-1:0]    offset;
  logic [tlbpt_pkg::SLOT_W-1:0]      slot;
  logic [tlbpt_pkg::FRAME_W-1:0]     tlb_tag   [tlbpt_pkg::TLB_DEPTH];
  logic [tlbpt_pkg::FRAME_W-1:0]     tlb_frame [tlbpt_pkg::TLB_DEPTH];
  logic [tlbpt_pkg::TLB_DEPTH-1:0]   tlb_valid;
  logic [tlbpt_pkg::FRAME_CNT_W-1:0] frames_used;
  logic [tlbpt_pkg::FRAME_W-1:0]     res_frame;
  logic                              res_hit;
  logic                              res_fault;
  logic [tlbpt_pkg::FRAME_W-1:0]     walk_frame;
  logic                              lookup_hit;
  logic                              in_accept;
  logic                              out_load;
  logic                              walk_we;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign slot      = rem_rsp.rem[tlbpt_pkg::SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= tlbpt_pkg::ENTRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entries <= tlb_entries;
    end
  end

  always_comb begin
    if (entries == '0) begin
      divisor = tlbpt_pkg::DIV_W'(1);
    end else if (entries > tlbpt_pkg::CFG_W'(tlbpt_pkg::TLB_DEPTH)) begin
      divisor = tlbpt_pkg::DIV_W'(tlbpt_pkg::TLB_DEPTH);
    end else begin
      divisor = tlbpt_pkg::DIV_W'(entries);
    end
  end

  always_comb begin
    rem_req.start    = in_accept;
    rem_req.dividend = logical_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
    rem_req.divisor  = divisor;
  end

  tlbpt_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  assign lookup_hit = tlb_valid[slot] && (tlb_tag[slot] == page);
  assign walk_frame = pt_rsp.valid ? pt_rsp.frame : frames_used[tlbpt_pkg::FRAME_W-1:0];

  always_comb begin
    pt_req.we    = walk_we && !pt_rsp.valid;
    pt_req.page  = page;
    pt_req.frame = frames_used[tlbpt_pkg::FRAME_W-1:0];
  end

  tlbpt_page_table u_pt (
    .clk     (clk),
    .rst     (rst),
    .rd_page (page),
    .req     (pt_req),
    .rsp     (pt_rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      tlbpt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tlbpt_pkg::ST_DIVIDE;
        end
      end
      tlbpt_pkg::ST_DIVIDE: begin
        if (rem_rsp.done) begin
          state_next = tlbpt_pkg::ST_LOOKUP;
        end
      end
      tlbpt_pkg::ST_LOOKUP: begin
        state_next = lookup_hit ? tlbpt_pkg::ST_DONE : tlbpt_pkg::ST_WALK;
      end
      tlbpt_pkg::ST_WALK: begin
        state_next = tlbpt_pkg::ST_DONE;
      end
      tlbpt_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = tlbpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tlbpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    walk_we  = 1'b0;
    out_load = 1'b0;
    case (state)
      tlbpt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      tlbpt_pkg::ST_WALK: begin
        walk_we = 1'b1;
      end
      tlbpt_pkg::ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= tlbpt_pkg::ST_IDLE;
      tlb_valid        <= '0;
      frames_used      <= '0;
      out_valid        <= 1'b0;
      translated_count <= '0;
      tlb_hit_count    <= '0;
      fault_count      <= '0;
    end else begin
      state <= state_next;
      if (walk_we) begin
        tlb_valid[slot] <= 1'b1;
      end
      if (pt_req.we) begin
        frames_used <= frames_used + 1'b1;
      end
      if (out_load) begin
        out_valid        <= 1'b1;
        translated_count <= translated_count + 1'b1;
        tlb_hit_count    <= tlb_hit_count + tlbpt_pkg::CNT_W'(res_hit);
        fault_count      <= fault_count + tlbpt_pkg::CNT_W'(res_fault);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      page   <= logical_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
      offset <= logical_address[tlbpt_pkg::OFFSET_W-1:0];
    end
    if (state == tlbpt_pkg::ST_LOOKUP) begin
      res_hit   <= lookup_hit;
      res_fault <= 1'b0;
      res_frame <= tlb_frame[slot];
    end
    if (walk_we) begin
      res_fault       <= !pt_rsp.valid;
      res_frame       <= walk_frame;
      tlb_tag[slot]   <= page;
      tlb_frame[slot] <= walk_frame;
    end
    if (out_load) begin
      physical_address <= {res_frame, offset};
      tlb_hit          <= res_hit;
      fault_flag       <= res_fault;
    end
  end

  `TLBPT_ASSERT_NEXT(a_accept_divides, clk, rst, in_accept, state == tlbpt_pkg::ST_DIVIDE)
  `TLBPT_ASSERT_NOW(a_slot_in_range, clk, rst, rem_rsp.done, rem_rsp.rem < divisor)
  `TLBPT_ASSERT_NOW(a_hit_not_fault, clk, rst, out_valid, !(tlb_hit && fault_flag))
  `TLBPT_ASSERT_NEXT(a_count_step, clk, rst, out_load, translated_count == $past(translated_count) + 1'b1)

endmodule

// File: tb/tlb_translation_checker.sv
// ----------------------------------------------------------------------------
// tlb_translation_checker
// Watches the request, result and register channels of the TLB page table
// translator. Keeps its own TLB, page table, frame allocator and counters,
// predicts every result and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module tlb_translation_checker
  import tlbpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [ADDR_W-1:0]   logical_address,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [ADDR_W-1:0]   physical_address,
  input  logic                tlb_hit,
  input  logic                fault_flag,
  input  logic [CNT_W-1:0]    translated_count,
  input  logic [CNT_W-1:0]    tlb_hit_count,
  input  logic [CNT_W-1:0]    fault_count,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_W-1:0]    tlb_entries,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ADDR_W-1:0] phys;
    logic              hit;
    logic              fault;
    logic [CNT_W-1:0]  xlat;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  faults;
  } translation_t;

  logic [PAGE_W-1:0]      tag_mem   [TLB_DEPTH];
  logic [FRAME_W-1:0]     frame_mem [TLB_DEPTH];
  logic                   tag_ok    [TLB_DEPTH];
  logic [FRAME_W-1:0]     page_map  [PAGE_COUNT];
  logic                   page_ok   [PAGE_COUNT];
  logic [FRAME_CNT_W-1:0] next_frame;
  logic [CNT_W-1:0]       xlat_cnt;
  logic [CNT_W-1:0]       hit_cnt;
  logic [CNT_W-1:0]       fault_cnt;
  logic [CFG_W-1:0]       entries_in_use;
  translation_t           awaited_q[$];
  translation_t           got;
  translation_t           want;
  int                     errors = 0;

  function automatic translation_t translate(input logic [ADDR_W-1:0] addr);
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offs;
    logic [FRAME_W-1:0]  frame;
    int                  n;
    int                  slot;
    translation_t        r;
    page = addr[ADDR_W-1:OFFSET_W];
    offs = addr[OFFSET_W-1:0];
    n = int'(entries_in_use);
    if (n == 0) n = 1;
    if (n > TLB_DEPTH) n = TLB_DEPTH;
    slot = int'(page) % n;
    r = '0;
    xlat_cnt = xlat_cnt + 1'b1;
    if (tag_ok[slot] && tag_mem[slot] == page) begin
      r.hit = 1'b1;
      hit_cnt = hit_cnt + 1'b1;
      frame = frame_mem[slot];
    end else begin
      if (page_ok[page]) begin
        frame = page_map[page];
      end else begin
        r.fault = 1'b1;
        fault_cnt = fault_cnt + 1'b1;
        frame = next_frame[FRAME_W-1:0];
        next_frame = next_frame + 1'b1;
        page_map[page] = frame;
        page_ok[page] = 1'b1;
      end
      tag_mem[slot] = page;
      frame_mem[slot] = frame;
      tag_ok[slot] = 1'b1;
    end
    r.phys = {frame, offs};
    r.xlat = xlat_cnt;
    r.hits = hit_cnt;
    r.faults = fault_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
                             input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TLB_DEPTH; i++) tag_ok[i] = 1'b0;
      for (int i = 0; i < PAGE_COUNT; i++) page_ok[i] = 1'b0;
      next_frame = '0;
      xlat_cnt = '0;
      hit_cnt = '0;
      fault_cnt = '0;
      entries_in_use = ENTRIES_RESET;
      awaited_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) entries_in_use = tlb_entries;
      if (out_valid && out_ready) begin
        got = '{physical_address, tlb_hit, fault_flag, translated_count,
                tlb_hit_count, fault_count};
        if (awaited_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
        end else begin
          want = awaited_q.pop_front();
          check_field("physical_address", CNT_W'(want.phys), CNT_W'(got.phys));
          check_field("tlb_hit", CNT_W'(want.hit), CNT_W'(got.hit));
          check_field("fault_flag", CNT_W'(want.fault), CNT_W'(got.fault));
          check_field("translated_count", want.xlat, got.xlat);
          check_field("tlb_hit_count", want.hits, got.hits);
          check_field("fault_count", want.faults, got.faults);
        end
      end
      if (in_valid && in_ready) awaited_q.push_back(translate(logical_address));
    end
    pending <= awaited_q.size();
    fail_count <= errors;
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the TLB page table translator. Runs directed
// addresses around slot conflicts, hits and faults, then random translations
// under several TLB sizes and idle patterns; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbpt_pkg::*;

  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 135;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [ADDR_W-1:0]   logical_address;
  logic                out_valid;
  logic                out_ready;
  logic [ADDR_W-1:0]   physical_address;
  logic                tlb_hit;
  logic                fault_flag;
  logic [CNT_W-1:0]    translated_count;
  logic [CNT_W-1:0]    tlb_hit_count;
  logic [CNT_W-1:0]    fault_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    tlb_entries;
  int                  fail_count;
  int                  pending;

  int                  send_gap_pct;
  int                  out_stall_pct;
  logic [PAGE_W-1:0]   hot_base;
  int                  hot_span;

  logic [ADDR_W-1:0] opening_addrs [13] = '{
    16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h1034, 16'h0012, 16'h10AB,
    16'h7F80, 16'h8001, 16'h8001, 16'hAA55, 16'h55AA, 16'h2010
  };
  logic [ADDR_W-1:0] one_slot_addrs [4] = '{16'h0011, 16'hFF22, 16'hFF33, 16'h0144};
  logic [CFG_W-1:0]  phase_entries [PHASES] = '{
    CFG_W'(16), CFG_W'(1), CFG_W'(0), CFG_W'(31), CFG_W'(7), CFG_W'(17), CFG_W'(2),
    CFG_W'(16)
  };

  tlb_page_table_translator dut (
    .clk, .rst, .in_valid, .in_ready, .logical_address, .out_valid, .out_ready,
    .physical_address, .tlb_hit, .fault_flag, .translated_count, .tlb_hit_count,
    .fault_count, .cfg_valid, .cfg_ready, .tlb_entries
  );

  tlb_translation_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .logical_address, .out_valid, .out_ready,
    .physical_address, .tlb_hit, .fault_flag, .translated_count, .tlb_hit_count,
    .fault_count, .cfg_valid, .cfg_ready, .tlb_entries, .fail_count, .pending
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) < out_stall_pct) ? 1'b0 : 1'b1;
  end

  task automatic send_address(input logic [ADDR_W-1:0] addr);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
    in_valid <= 1'b1;
    logical_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_entries(input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    tlb_entries <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [PAGE_W-1:0] page;
    if ($urandom_range(99) < 70) page = hot_base + PAGE_W'($urandom_range(0, hot_span));
    else page = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
    return {page, OFFSET_W'($urandom_range(0, 255))};
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    logical_address = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    tlb_entries = '0;
    send_gap_pct = 0;
    out_stall_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (opening_addrs[i]) send_address(opening_addrs[i]);
    write_entries(CFG_W'(0));
    foreach (one_slot_addrs[i]) send_address(one_slot_addrs[i]);
    write_entries(CFG_W'(31));
    send_address(16'hFF44);
    send_address(16'h2F01);

    for (int p = 0; p < PHASES; p++) begin
      write_entries(phase_entries[p]);
      send_gap_pct = (p % 4 == 1) ? 61 : (p % 4 == 3) ? 20 : 0;
      out_stall_pct = (p % 4 == 2) ? 61 : (p % 4 == 3) ? 20 : 0;
      hot_base = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
      hot_span = $urandom_range(1, 2 * TLB_DEPTH);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 1 && k == 60) drain_results();
        send_address(pick_address());
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
